FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// Implication form: antecedent seen, consequent must follow on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

FILE: sv/lacomp_pkg.sv
package lacomp_pkg;

	// lookahead line
	localparam int LA_DEPTH = 256;
	localparam int LA_AW    = $clog2(LA_DEPTH);

	// serial arithmetic unit widths
	localparam int MD_AW = 32;
	localparam int MD_BW = 16;

	localparam logic [13:0] UNITY = 14'd256;

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

endpackage

FILE: sv/lacomp_if.sv
// input word channel
interface lacomp_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] sample;

	modport source (output valid, command, sample, input ready);
	modport sink   (input valid, command, sample, output ready);
endinterface

// result word channel
interface lacomp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic [13:0]        gain_ratio;
	logic signed [15:0] peak;

	modport source (output valid, sample_out, gain_ratio, peak, input ready);
	modport sink   (input valid, sample_out, gain_ratio, peak, output ready);
endinterface

FILE: sv/lacomp_muldiv.sv
// Bit-serial multiplier / restoring divider, one bit per cycle
module lacomp_muldiv (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lacomp_pkg::md_req_t                    req,
	input  logic [lacomp_pkg::MD_AW-1:0]           a,
	input  logic [lacomp_pkg::MD_BW-1:0]           b,
	output logic                                   done,
	output logic [lacomp_pkg::MD_AW-1:0]           result
);
	import lacomp_pkg::*;

	localparam int CW = $clog2(MD_AW + 1);

	logic             busy_q;
	logic             done_q;
	md_op_t           op_q;
	logic [CW-1:0]    cnt_q;
	logic [MD_AW-1:0] acc_q;
	logic [MD_AW-1:0] sh_q;
	logic [MD_BW-1:0] bsh_q;
	logic [MD_BW-1:0] rem_q;

	logic [MD_BW:0]   trial;
	logic             ge;

	// divider trial subtract
	always_comb begin
		trial = {rem_q, sh_q[MD_AW-1]};
		ge    = trial >= {1'b0, bsh_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= MD_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == MD_MUL) ? CW'(MD_BW) : CW'(MD_AW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sh_q  <= a;
			bsh_q <= b;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == MD_MUL) begin
				if (bsh_q[0])
					acc_q <= acc_q + sh_q;
				sh_q  <= {sh_q[MD_AW-2:0], 1'b0};
				bsh_q <= {1'b0, bsh_q[MD_BW-1:1]};
			end else begin
				rem_q <= ge ? MD_BW'(trial - {1'b0, bsh_q}) : trial[MD_BW-1:0];
				sh_q  <= {sh_q[MD_AW-2:0], ge};
			end
		end
	end

	assign done   = done_q;
	assign result = (op_q == MD_MUL) ? acc_q : sh_q;

endmodule

FILE: sv/lookahead_audio_compressor_core.sv
// Lookahead audio compressor with attack / hold / release envelope.
// Channels: in_ch takes a word {command, sample}; command 0 processes the
// sample, command 1 flushes the lookahead line and loads the start phase.
// out_ch gives exactly one word {sample_out, gain_ratio, peak} per input word.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 enable,
// 1 ratio, 2 attack, 3 hold, 4 release, 5 threshold, 6 makeup gain,
// 7 start mode); write only while no word is in flight.
// Flush and bypass words go from the idle state straight to the final state,
// which loads the output register. A compressed word runs the bit-serial
// multiply/divide unit: one divide and one multiply for output scaling
// alone, up to three of each when the envelope ramp and an attack restart
// also need it. One word is worked on at a time; the next is taken while a
// finished result waits in the output register.
// Reset: configuration to defaults, envelope in hold, ratio one, peak zero,
// lookahead line reads as zero (valid bits cleared at once).
// A stalled receiver holds the result; a second finished result waits in
// the final state until the output register frees.
module lookahead_audio_compressor_core (
	input  logic                       clk,
	input  logic                       arst_n,
	lacomp_in_if.sink                  in_ch,
	lacomp_out_if.source               out_ch,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [15:0]                cfg_data
);
	import lacomp_pkg::*;

	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_RATIO     = 3'd1;
	localparam logic [2:0] REG_ATTACK    = 3'd2;
	localparam logic [2:0] REG_HOLD      = 3'd3;
	localparam logic [2:0] REG_RELEASE   = 3'd4;
	localparam logic [2:0] REG_THRESHOLD = 3'd5;
	localparam logic [2:0] REG_GAIN      = 3'd6;
	localparam logic [2:0] REG_START     = 3'd7;

	typedef enum logic [1:0] {
		PH_OFF     = 2'd0,
		PH_RELEASE = 2'd1,
		PH_HOLD    = 2'd2,
		PH_ATTACK  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TRIG_MUL,
		S_TRIG_DIV,
		S_ENV,
		S_ENV_MUL,
		S_ENV_DIV,
		S_OUT_DIV,
		S_OUT_MUL,
		S_DONE
	} state_t;

	// configuration registers
	logic        en_q;
	logic [5:0]  ratio_q;
	logic [15:0] atk_q, hold_q, rel_q, gain_q;
	logic [14:0] thr_q;
	logic [1:0]  smode_q;

	// envelope and control state
	state_t             state_q;
	logic               issued_q;
	phase_t             phase_q;
	logic [15:0]        atk_cnt_q, hold_cnt_q, rel_cnt_q;
	logic [13:0]        cr_q;
	logic signed [15:0] peak_q;
	logic [MD_AW-1:0]   prod_q;
	logic signed [15:0] y_q;
	logic [LA_AW-1:0]   ptr_q;

	// lookahead memory
	logic [15:0]         mem_q [LA_DEPTH];
	logic [LA_DEPTH-1:0] vld_q;
	logic [15:0]         old_q;
	logic                old_vld_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic [13:0]        out_ratio_q;
	logic signed [15:0] out_peak_q;

	// arithmetic unit
	md_req_t          md_req;
	logic [MD_AW-1:0] md_a;
	logic [MD_BW-1:0] md_b;
	logic             md_done;
	logic [MD_AW-1:0] md_result;

	logic               in_acc;
	logic [15:0]        in_mag;
	logic [5:0]         r_eff;
	logic [4:0]         r_m1;
	logic [13:0]        r_full;
	phase_t             start_ph;
	logic [15:0]        old_eff;
	logic [15:0]        old_mag;
	logic [23:0]        scaled;
	logic signed [15:0] sat_y;
	logic [15:0]        rel_dec;

	lacomp_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (md_a),
		.b      (md_b),
		.done   (md_done),
		.result (md_result)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && (state_q == S_IDLE);

	// derived values
	always_comb begin
		in_mag   = in_ch.sample[15] ? 16'(~in_ch.sample + 16'sd1) : in_ch.sample;
		r_eff    = (ratio_q == 6'd0) ? 6'd1 : ((ratio_q > 6'd32) ? 6'd32 : ratio_q);
		r_m1     = 5'(r_eff - 6'd1);
		r_full   = {r_eff, 8'd0};
		rel_dec  = rel_cnt_q - 16'd1;
		case (smode_q)
			2'd0:    start_ph = PH_OFF;
			2'd1:    start_ph = PH_RELEASE;
			default: start_ph = PH_HOLD;
		endcase
		old_eff  = old_vld_q ? old_q : 16'd0;
		old_mag  = old_eff[15] ? 16'(~old_eff + 16'd1) : old_eff;
		scaled   = md_result[31:8];
		if (old_eff[15])
			sat_y = (scaled > 24'd32768) ? -16'sd32768 : 16'(~scaled[15:0] + 16'd1);
		else
			sat_y = (scaled > 24'd32767) ? 16'sd32767 : scaled[15:0];
	end

	// operand selection for the serial unit
	always_comb begin
		md_req.start = 1'b0;
		md_req.op    = MD_MUL;
		md_a         = '0;
		md_b         = '0;
		case (state_q)
			S_TRIG_MUL: begin
				md_req.start = !issued_q;
				md_a         = {18'd0, cr_q};
				md_b         = atk_q;
			end
			S_TRIG_DIV: begin
				md_req.start = !issued_q;
				md_req.op    = MD_DIV;
				md_a         = {8'd0, prod_q[31:8]};
				md_b         = {10'd0, r_eff};
			end
			S_ENV_MUL: begin
				md_req.start = !issued_q;
				md_a         = {16'd0, (phase_q == PH_ATTACK) ? atk_cnt_q : rel_cnt_q};
				md_b         = {11'd0, r_m1};
			end
			S_ENV_DIV: begin
				md_req.start = !issued_q;
				md_req.op    = MD_DIV;
				md_a         = {prod_q[23:0], 8'd0};
				md_b         = (phase_q == PH_ATTACK) ? atk_q : rel_q;
			end
			S_OUT_DIV: begin
				md_req.start = !issued_q;
				md_req.op    = MD_DIV;
				md_a         = {8'd0, old_mag, 8'd0};
				md_b         = {2'd0, (cr_q < UNITY) ? UNITY : cr_q};
			end
			S_OUT_MUL: begin
				md_req.start = !issued_q;
				md_a         = prod_q;
				md_b         = gain_q;
			end
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			ratio_q <= 6'd5;
			atk_q   <= 16'd0;
			hold_q  <= 16'd9600;
			rel_q   <= 16'd4800;
			thr_q   <= 15'd631;
			gain_q  <= 16'd8090;
			smode_q <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:    en_q    <= cfg_data[0];
				REG_RATIO:     ratio_q <= cfg_data[5:0];
				REG_ATTACK:    atk_q   <= cfg_data;
				REG_HOLD:      hold_q  <= cfg_data;
				REG_RELEASE:   rel_q   <= cfg_data;
				REG_THRESHOLD: thr_q   <= cfg_data[14:0];
				REG_GAIN:      gain_q  <= cfg_data;
				REG_START:     smode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// lookahead memory: read oldest, write newest at the same slot
	always_ff @(posedge clk) begin
		if (in_acc && !in_ch.command && en_q) begin
			old_q        <= mem_q[ptr_q];
			mem_q[ptr_q] <= in_ch.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			old_vld_q <= 1'b0;
		end else if (in_acc && in_ch.command) begin
			vld_q <= '0;
		end else if (in_acc && en_q) begin
			old_vld_q    <= vld_q[ptr_q];
			vld_q[ptr_q] <= 1'b1;
		end
	end

	// sequencer, envelope and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issued_q     <= 1'b0;
			phase_q      <= PH_HOLD;
			atk_cnt_q    <= 16'd0;
			hold_cnt_q   <= 16'd0;
			rel_cnt_q    <= 16'd4800;
			cr_q         <= UNITY;
			peak_q       <= 16'sd0;
			ptr_q        <= '0;
			prod_q       <= '0;
			y_q          <= 16'sd0;
			out_valid_q  <= 1'b0;
			out_sample_q <= 16'sd0;
			out_ratio_q  <= UNITY;
			out_peak_q   <= 16'sd0;
		end else begin
			// the final state reloads the output register itself
			if (out_valid_q && out_ch.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			if (md_req.start)
				issued_q <= 1'b1;
			else if (md_done)
				issued_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.command) begin
							ptr_q   <= '0;
							phase_q <= start_ph;
							y_q     <= 16'sd0;
							state_q <= S_DONE;
						end else if (!en_q) begin
							y_q     <= in_ch.sample;
							state_q <= S_DONE;
						end else begin
							ptr_q <= (ptr_q == LA_AW'(LA_DEPTH - 1)) ? '0 : ptr_q + LA_AW'(1);
							if (phase_q != PH_ATTACK && in_mag > {1'b0, thr_q}) begin
								phase_q    <= PH_ATTACK;
								hold_cnt_q <= 16'd0;
								rel_cnt_q  <= rel_q;
								state_q    <= (phase_q == PH_OFF) ? S_ENV : S_TRIG_MUL;
							end else begin
								state_q <= S_ENV;
							end
						end
					end
				end
				S_TRIG_MUL: begin
					if (issued_q && md_done) begin
						prod_q  <= md_result;
						state_q <= S_TRIG_DIV;
					end
				end
				S_TRIG_DIV: begin
					if (issued_q && md_done) begin
						atk_cnt_q <= (md_result > {16'd0, atk_q}) ? atk_q : md_result[15:0];
						state_q   <= S_ENV;
					end
				end
				// one envelope step
				S_ENV: begin
					state_q <= S_OUT_DIV;
					case (phase_q)
						PH_ATTACK: begin
							if (atk_cnt_q < atk_q) begin
								atk_cnt_q <= atk_cnt_q + 16'd1;
								state_q   <= S_ENV_MUL;
							end else begin
								phase_q   <= PH_HOLD;
								atk_cnt_q <= 16'd0;
							end
						end
						PH_RELEASE: begin
							if (rel_cnt_q != 16'd0) begin
								rel_cnt_q <= rel_dec;
								if (rel_dec >= rel_q)
									cr_q <= r_full;
								else
									state_q <= S_ENV_MUL;
							end else begin
								phase_q   <= PH_OFF;
								rel_cnt_q <= rel_q;
							end
						end
						PH_HOLD: begin
							if (hold_cnt_q >= hold_q) begin
								phase_q    <= PH_RELEASE;
								hold_cnt_q <= 16'd0;
							end else begin
								hold_cnt_q <= hold_cnt_q + 16'd1;
								cr_q       <= r_full;
							end
						end
						default: ;
					endcase
				end
				S_ENV_MUL: begin
					if (issued_q && md_done) begin
						prod_q  <= md_result;
						state_q <= S_ENV_DIV;
					end
				end
				S_ENV_DIV: begin
					if (issued_q && md_done) begin
						cr_q    <= UNITY + md_result[13:0];
						state_q <= S_OUT_DIV;
					end
				end
				S_OUT_DIV: begin
					if (issued_q && md_done) begin
						prod_q  <= md_result;
						state_q <= S_OUT_MUL;
					end
				end
				S_OUT_MUL: begin
					if (issued_q && md_done) begin
						y_q <= sat_y;
						if (sat_y > peak_q)
							peak_q <= sat_y;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= y_q;
						out_ratio_q  <= cr_q;
						out_peak_q   <= peak_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.gain_ratio = out_ratio_q;
	assign out_ch.peak       = out_peak_q;

endmodule

FILE: sv/lacomp_checker.sv
`include "assert_macros.svh"

// Port-level checks on the compressor
module lacomp_core_props (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [13:0]        gain_ratio,
	input logic signed [15:0] peak
);

	// a result word stays offered until taken
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// one word in flight: input closes right after an accept
	`ASSERT_NEXT(a_in_close, clk, arst_n, in_valid && in_ready, !in_ready)

	// reported ratio stays between one and the largest ratio
	`ASSERT_CLK(a_ratio_rng, clk, arst_n,
		out_valid |-> (gain_ratio >= 14'd256 && gain_ratio <= 14'd8192))

	// peak never falls from one word to the next
	`ASSERT_NEXT(a_peak_mono, clk, arst_n, out_valid && out_ready,
		!out_valid || peak >= $past(peak))

endmodule

bind lookahead_audio_compressor_core lacomp_core_props u_lacomp_core_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.gain_ratio (out_ch.gain_ratio),
	.peak       (out_ch.peak)
);
